[sv/sdisp_pkg.sv]
// Shared constants and codes for the stale task dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package sdisp_pkg;
  localparam int MAX_JOBS_DEF   = 64;
  localparam int STAMP_BITS_DEF = 32;

  // Fixed field widths
  localparam int IDX_IN_W  = 8;
  localparam int FIELD_W   = 32;
  localparam int OUTC_W    = 3;
  localparam int IDX_OUT_W = 6;
  localparam int JOBS_W    = 7;
  localparam int PAT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JOBS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATIENCE    = 2'd1;

  // Reset values of the registers
  localparam logic [JOBS_W-1:0] JOBS_RST = 7'd64;
  localparam logic [PAT_W-1:0]  PAT_RST  = 16'd3;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUT_ISSUED   = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_NO_TASK  = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_ACCEPTED = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_STALE    = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_RANGE    = 3'd4;

  // Request modes
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_REPORT  = 1'b1;
endpackage
`default_nettype wire

[sv/sdisp_if.sv]
// Channel interfaces of the stale task dispatcher.
`timescale 1ns / 1ps
`default_nettype none
interface sdisp_in_if;
  import sdisp_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [IDX_IN_W-1:0] job_index;
  logic [FIELD_W-1:0] job_stamp;
  logic [FIELD_W-1:0] now_time;
  modport source (output valid, mode, job_index, job_stamp, now_time, input ready);
  modport sink   (input valid, mode, job_index, job_stamp, now_time, output ready);
endinterface

interface sdisp_out_if;
  import sdisp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUTC_W-1:0]    outcome;
  logic [IDX_OUT_W-1:0] issued_index;
  logic [FIELD_W-1:0]   issued_stamp;
  logic                 advance_notice;
  modport source (output valid, outcome, issued_index, issued_stamp, advance_notice,
                  input ready);
  modport sink   (input valid, outcome, issued_index, issued_stamp, advance_notice,
                  output ready);
endinterface

interface sdisp_cfg_if;
  import sdisp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/stale_task_dispatcher_top.sv]
// Top level of the stale task dispatcher: sequencer, slot stores and retry FIFO.
`timescale 1ns / 1ps
`default_nettype none
// Job dispatcher with versioned slots. After reset a clearing pass sweeps the slot
// store (input not ready, configuration writes taken). A report passes from idle
// through the slot check and result states to the output register (an index out of
// range skips the check). A request scans N slots (jobs_in_use saturated at MAX_JOBS)
// after examining retry FIFO heads: every expired entry drained, plus one more when
// the drain stops at an unexpired head. Each examined head is a FIFO read followed by
// a slot and issue-time read. The minimum-stamp search walks the slot RAM one entry
// a cycle through a single shared comparator. The output is a register, so a new
// request is taken while an earlier result waits for out_ch.ready.
module stale_task_dispatcher_top
  import sdisp_pkg::*;
#(
  parameter int MAX_JOBS   = MAX_JOBS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sdisp_in_if.sink    in_ch,
  sdisp_out_if.source out_ch,
  sdisp_cfg_if.sink   cfg_ch
);
  localparam int IW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int SW = STAMP_BITS + 2;
  localparam int CB = SW - 1;   // completed bit
  localparam int PB = SW - 2;   // in-pool bit

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DF    = 4'd2;
  localparam logic [3:0] ST_DC    = 4'd3;
  localparam logic [3:0] ST_SCAN  = 4'd4;
  localparam logic [3:0] ST_ISSUE = 4'd5;
  localparam logic [3:0] ST_RCHK  = 4'd6;
  localparam logic [3:0] ST_RES   = 4'd7;

  logic [3:0]            state_r, state_nxt;
  logic [IW-1:0]         clr_r, clr_nxt;
  logic [JOBS_W-1:0]     jobs_r;
  logic [PAT_W-1:0]      pat_r;
  logic [IW-1:0]         head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [FIELD_W-1:0]    rstamp_r, rstamp_nxt, now_r, now_nxt;
  logic [IW-1:0]         j_r, j_nxt;
  logic [CW-1:0]         i_r, i_nxt;
  logic                  pend_r, pend_nxt;
  logic [IW-1:0]         pidx_r, pidx_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         best_r, best_nxt;
  logic [STAMP_BITS-1:0] bstamp_r, bstamp_nxt;
  logic [OUTC_W-1:0]     res_oc_r, res_oc_nxt;
  logic [IDX_OUT_W-1:0]  res_idx_r, res_idx_nxt;
  logic [FIELD_W-1:0]    res_stamp_r, res_stamp_nxt;
  logic                  res_note_r, res_note_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUTC_W-1:0]     out_oc_r, out_oc_nxt;
  logic [IDX_OUT_W-1:0]  out_idx_r, out_idx_nxt;
  logic [FIELD_W-1:0]    out_stamp_r, out_stamp_nxt;
  logic                  out_note_r, out_note_nxt;

  // Memory ports
  logic                  slot_we;
  logic [IW-1:0]         slot_waddr, slot_raddr;
  logic [SW-1:0]         slot_wdata, slot_rdata;
  logic                  time_we;
  logic [IW-1:0]         time_raddr;
  logic [FIELD_W-1:0]    time_rdata;
  logic                  fifo_we;
  logic [IW-1:0]         fifo_raddr, fifo_rdata;

  // Shared comparator
  logic [STAMP_BITS-1:0] cmp_b;
  logic                  cmp_lt, cmp_eq;

  logic [CW-1:0]         n_act;
  logic [FIELD_W-1:0]    age;
  logic                  expired;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    wrap_inc = (p == IW'(MAX_JOBS - 1)) ? '0 : p + 1'b1;
  endfunction

  sdisp_ram #(.DEPTH(MAX_JOBS), .WIDTH(SW)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  sdisp_ram #(.DEPTH(MAX_JOBS), .WIDTH(FIELD_W)) u_time_ram (
    .clk(clk), .we(time_we), .waddr(best_r), .wdata(now_r),
    .raddr(time_raddr), .rdata(time_rdata)
  );

  sdisp_ram #(.DEPTH(MAX_JOBS), .WIDTH(IW)) u_fifo_ram (
    .clk(clk), .we(fifo_we), .waddr(tail_r), .wdata(best_r),
    .raddr(fifo_raddr), .rdata(fifo_rdata)
  );

  sdisp_cmp #(.W(STAMP_BITS)) u_cmp (
    .a(slot_rdata[STAMP_BITS-1:0]), .b(cmp_b), .lt(cmp_lt), .eq(cmp_eq)
  );

  // Active slot count, saturated at MAX_JOBS
  always_comb begin
    if (32'(jobs_r) > 32'(MAX_JOBS)) begin
      n_act = CW'(MAX_JOBS);
    end else begin
      n_act = CW'(jobs_r);
    end
  end

  // Expiry check of the FIFO head
  assign age     = now_r - time_rdata;
  assign expired = slot_rdata[CB] || !(age < FIELD_W'(pat_r));

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.outcome        = out_oc_r;
  assign out_ch.issued_index   = out_idx_r;
  assign out_ch.issued_stamp   = out_stamp_r;
  assign out_ch.advance_notice = out_note_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    rstamp_nxt    = rstamp_r;
    now_nxt       = now_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    bstamp_nxt    = bstamp_r;
    res_oc_nxt    = res_oc_r;
    res_idx_nxt   = res_idx_r;
    res_stamp_nxt = res_stamp_r;
    res_note_nxt  = res_note_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_oc_nxt    = out_oc_r;
    out_idx_nxt   = out_idx_r;
    out_stamp_nxt = out_stamp_r;
    out_note_nxt  = out_note_r;
    slot_we       = 1'b0;
    slot_waddr    = idx_r;
    slot_wdata    = slot_rdata;
    slot_raddr    = idx_r;
    time_we       = 1'b0;
    time_raddr    = j_r;
    fifo_we       = 1'b0;
    fifo_raddr    = head_r;
    cmp_b         = bstamp_r;

    case (state_r)
      ST_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = '0;
        slot_wdata[PB] = 1'b1;
        if (clr_r == IW'(MAX_JOBS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          rstamp_nxt = in_ch.job_stamp;
          now_nxt    = in_ch.now_time;
          idx_nxt    = IW'(in_ch.job_index);
          i_nxt      = '0;
          pend_nxt   = 1'b0;
          found_nxt  = 1'b0;
          if (in_ch.mode == MODE_REQUEST) begin
            fifo_raddr = head_r;
            state_nxt  = (cnt_r != '0) ? ST_DF : ST_SCAN;
          end else if (32'(in_ch.job_index) < 32'(n_act)) begin
            slot_raddr = IW'(in_ch.job_index);
            state_nxt  = ST_RCHK;
          end else begin
            res_oc_nxt    = OUT_RANGE;
            res_idx_nxt   = '0;
            res_stamp_nxt = '0;
            res_note_nxt  = 1'b0;
            state_nxt     = ST_RES;
          end
        end
      end
      // FIFO head known: fetch its slot and issue time
      ST_DF: begin
        j_nxt      = fifo_rdata;
        slot_raddr = fifo_rdata;
        time_raddr = fifo_rdata;
        state_nxt  = ST_DC;
      end
      // Return an expired head to the pool
      ST_DC: begin
        state_nxt = ST_SCAN;
        if (expired) begin
          slot_we        = 1'b1;
          slot_waddr     = j_r;
          slot_wdata     = slot_rdata;
          slot_wdata[PB] = 1'b1;
          head_nxt       = wrap_inc(head_r);
          cnt_nxt        = cnt_r - 1'b1;
          if (cnt_r != CW'(1)) begin
            fifo_raddr = wrap_inc(head_r);
            state_nxt  = ST_DF;
          end
        end
      end
      // Walk the slots for the smallest pooled stamp
      ST_SCAN: begin
        if (i_r < n_act) begin
          slot_raddr = IW'(i_r);
          pidx_nxt   = IW'(i_r);
          pend_nxt   = 1'b1;
          i_nxt      = i_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_ISSUE;
          end
        end
        if (pend_r && slot_rdata[PB] && (!found_r || cmp_lt)) begin
          found_nxt  = 1'b1;
          best_nxt   = pidx_r;
          bstamp_nxt = slot_rdata[STAMP_BITS-1:0];
        end
      end
      ST_ISSUE: begin
        res_note_nxt = 1'b0;
        state_nxt    = ST_RES;
        if (found_r) begin
          slot_we    = 1'b1;
          slot_waddr = best_r;
          slot_wdata = {1'b0, 1'b0, bstamp_r};
          time_we    = 1'b1;
          if (32'(cnt_r) < 32'(MAX_JOBS)) begin
            fifo_we  = 1'b1;
            tail_nxt = wrap_inc(tail_r);
            cnt_nxt  = cnt_r + 1'b1;
          end
          res_oc_nxt    = OUT_ISSUED;
          res_idx_nxt   = IDX_OUT_W'(best_r);
          res_stamp_nxt = FIELD_W'(bstamp_r);
        end else begin
          res_oc_nxt    = OUT_NO_TASK;
          res_idx_nxt   = '0;
          res_stamp_nxt = '0;
        end
      end
      // Judge a report against the stored stamp
      ST_RCHK: begin
        cmp_b         = STAMP_BITS'(rstamp_r);
        res_idx_nxt   = IDX_OUT_W'(idx_r);
        res_stamp_nxt = FIELD_W'(slot_rdata[STAMP_BITS-1:0]);
        res_note_nxt  = (idx_r == '0);
        state_nxt     = ST_RES;
        if (cmp_eq) begin
          slot_we    = 1'b1;
          slot_waddr = idx_r;
          slot_wdata = {1'b1, slot_rdata[PB], slot_rdata[STAMP_BITS-1:0] + 1'b1};
          res_oc_nxt = OUT_ACCEPTED;
        end else begin
          res_oc_nxt = OUT_STALE;
        end
      end
      ST_RES: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_oc_nxt    = res_oc_r;
          out_idx_nxt   = res_idx_r;
          out_stamp_nxt = res_stamp_r;
          out_note_nxt  = res_note_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      jobs_r      <= JOBS_RST;
      pat_r       <= PAT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_JOBS_IN_USE: jobs_r <= cfg_ch.data[JOBS_W-1:0];
          CFG_PATIENCE:    pat_r  <= cfg_ch.data[PAT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    rstamp_r    <= rstamp_nxt;
    now_r       <= now_nxt;
    j_r         <= j_nxt;
    i_r         <= i_nxt;
    pend_r      <= pend_nxt;
    pidx_r      <= pidx_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    bstamp_r    <= bstamp_nxt;
    res_oc_r    <= res_oc_nxt;
    res_idx_r   <= res_idx_nxt;
    res_stamp_r <= res_stamp_nxt;
    res_note_r  <= res_note_nxt;
    out_oc_r    <= out_oc_nxt;
    out_idx_r   <= out_idx_nxt;
    out_stamp_r <= out_stamp_nxt;
    out_note_r  <= out_note_nxt;
  end
endmodule
`default_nettype wire

[sv/sdisp_ram.sv]
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sdisp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/sdisp_cmp.sv]
// Shared stamp comparator: unsigned less-than and equality.
`timescale 1ns / 1ps
`default_nettype none
module sdisp_cmp #(
  parameter int W = 32
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              lt,
  output logic              eq
);
  assign lt = (a < b);
  assign eq = (a == b);
endmodule
`default_nettype wire

[sv/sdisp_chk.sv]
// Port-level checker for the stale task dispatcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sdisp_chk
  import sdisp_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [OUTC_W-1:0]    outcome,
  input wire logic [IDX_OUT_W-1:0] issued_index,
  input wire logic [FIELD_W-1:0]   issued_stamp,
  input wire logic                 advance_notice
);
  // A held result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(outcome))
    else $error("result dropped or changed while stalled");

  // One request in flight: ready drops after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  // No task and out of range carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (outcome == OUT_NO_TASK || outcome == OUT_RANGE) |->
      issued_index == '0 && issued_stamp == '0 && !advance_notice)
    else $error("nonzero fields on an empty result");

  // Advance notice only on judged reports for slot zero
  a_notice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && advance_notice |->
      (outcome == OUT_ACCEPTED || outcome == OUT_STALE) && issued_index == '0)
    else $error("advance notice on wrong result");
endmodule

bind stale_task_dispatcher_top sdisp_chk u_sdisp_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .outcome(out_ch.outcome),
  .issued_index(out_ch.issued_index),
  .issued_stamp(out_ch.issued_stamp),
  .advance_notice(out_ch.advance_notice)
);
`default_nettype wire
